// ----- hw/rtl/slid_pkg.sv -----
`timescale 1ns / 1ps

package slid_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int COUNT_W      = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  // Broadcast command to every cell, already qualified (insert only when not full,
  // delete only when a match exists)
  typedef struct packed {
    logic ins;
    logic del;
    logic clr;
  } cmd_t;

  // What a cell shows its neighbours
  typedef struct packed {
    logic signed [VAL_W-1:0] entry;
    logic                    valid;
    logic                    lt;     // valid and entry below the item value
  } link_t;

endpackage

// ----- hw/rtl/slid_cell.sv -----
`timescale 1ns / 1ps

module slid_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  slid_pkg::cmd_t                   cmd,
  input  logic signed [slid_pkg::VAL_W-1:0] value,
  input  slid_pkg::link_t                  left,
  input  slid_pkg::link_t                  right,
  output slid_pkg::link_t                  own,
  output logic                             eq
);
  import slid_pkg::*;

  logic signed [VAL_W-1:0] entry_r, entry_nxt;
  logic                    valid_r, valid_nxt;
  logic                    lt;

  assign lt  = valid_r && (entry_r < value);
  assign eq  = valid_r && (entry_r == value);
  assign own = '{entry: entry_r, valid: valid_r, lt: lt};

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (cmd.clr) begin
      valid_nxt = 1'b0;
    end else if (cmd.ins && !lt) begin
      // the slot just past the smaller entries takes the new value, the rest shift up
      entry_nxt = left.lt ? value : left.entry;
      valid_nxt = valid_r | left.valid;
    end else if (cmd.del && valid_r && !lt) begin
      // from the first equal entry onwards, pull down from the right
      entry_nxt = right.entry;
      valid_nxt = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/sorted_list_insert_delete.sv -----
`timescale 1ns / 1ps
// Channel  Ports                                              Direction
// input    start, busy, in_op, in_value                       in (busy out)
// result   out_valid, out_status, out_count, out_smallest,    out
//          out_smallest_valid
//
// One item per cycle: every cell compares its entry with the value and
// shifts in the same cycle, so busy stays low.
// The result appears in the cycle after the item is taken, for one cycle.
// Synchronous reset empties the store; no clearing pass is needed.
// The receiver cannot stall; results are never held back.

module sorted_list_insert_delete #(
  parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_op,
  input  logic signed [slid_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [slid_pkg::COUNT_W-1:0]        out_count,
  output logic signed [slid_pkg::VAL_W-1:0]   out_smallest,
  output logic                                out_smallest_valid
);
  import slid_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  link_t              links [CAPACITY];
  link_t              lefts [CAPACITY];
  link_t              rights[CAPACITY];
  logic [CAPACITY-1:0] eqs;

  cmd_t          cmd;
  logic          accept;
  logic          full;
  logic          found;
  op_t           op;
  logic [CW-1:0] occ_r, occ_nxt;
  status_t       status_r, status_nxt;
  logic          out_valid_r;
  logic [CW+COUNT_W-1:0] occ_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = op_t'(in_op);
  assign full   = links[CAPACITY-1].valid;
  assign found  = |eqs;

  always_comb begin
    cmd        = '0;
    status_nxt = ST_DONE;
    occ_nxt    = occ_r;
    if (accept) begin
      unique case (op)
        OP_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            occ_nxt = occ_r + CW'(1);
          end
        end
        OP_DELETE: begin
          if (found) begin
            cmd.del = 1'b1;
            occ_nxt = occ_r - CW'(1);
          end else begin
            status_nxt = ST_MISSING;
          end
        end
        OP_CLEAR: begin
          cmd.clr = 1'b1;
          occ_nxt = '0;
        end
        default: ; // undefined code: no change
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{entry: '0, valid: 1'b1, lt: 1'b1};
    end else begin : g_mid
      assign lefts[i] = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rights[i] = '{entry: '0, valid: 1'b0, lt: 1'b0};
    end else begin : g_inner
      assign rights[i] = links[i+1];
    end

    slid_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .value (in_value),
      .left  (lefts[i]),
      .right (rights[i]),
      .own   (links[i]),
      .eq    (eqs[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      status_r    <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      status_r    <= status_nxt;
      out_valid_r <= accept;
    end
  end

  // results read straight off the state updated by the item
  assign occ_ext            = {{COUNT_W{1'b0}}, occ_r};
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_count          = occ_ext[COUNT_W-1:0];
  assign out_smallest_valid = links[0].valid;
  assign out_smallest       = links[0].valid ? links[0].entry : '0;

endmodule
